// ----- src/bnc_pkg.sv -----
package bnc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;
   localparam int SYMBOL_W = 8;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 2;
   localparam int SCORE_W = 63;
   localparam int COUNT_W = 6;
   localparam int COUNT_MAX = 63;
   localparam int RSP_DATA_W = 72;
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   localparam logic [SYMBOL_W-1:0] CH_ROUND_OPEN = 8'h28;
   localparam logic [SYMBOL_W-1:0] CH_ROUND_CLOSE = 8'h29;
   localparam logic [SYMBOL_W-1:0] CH_SQUARE_OPEN = 8'h5B;
   localparam logic [SYMBOL_W-1:0] CH_SQUARE_CLOSE = 8'h5D;
   localparam logic [SYMBOL_W-1:0] CH_CURLY_OPEN = 8'h7B;
   localparam logic [SYMBOL_W-1:0] CH_CURLY_CLOSE = 8'h7D;
   localparam logic [SYMBOL_W-1:0] CH_ANGLE_OPEN = 8'h3C;
   localparam logic [SYMBOL_W-1:0] CH_ANGLE_CLOSE = 8'h3E;

   typedef enum logic [KIND_W-1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_ANGLE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_BALANCED   = 2'd0,
      STATUS_INCOMPLETE = 2'd1,
      STATUS_CORRUPTED  = 2'd2,
      STATUS_OVERFLOW   = 2'd3
   } status_type;

   typedef struct packed {
      logic     hit;
      kind_type kind;
   } bracket_type;

   typedef struct packed {
      logic     clear;
      logic     step;
      kind_type digit_kind;
   } acc_ctl_type;

   function automatic bracket_type opener_decode(input logic [SYMBOL_W-1:0] sym);
      bracket_type res;
      res.hit = 1'b1;
      res.kind = KIND_ROUND;
      case (sym)
         CH_ROUND_OPEN:  res.kind = KIND_ROUND;
         CH_SQUARE_OPEN: res.kind = KIND_SQUARE;
         CH_CURLY_OPEN:  res.kind = KIND_CURLY;
         CH_ANGLE_OPEN:  res.kind = KIND_ANGLE;
         default:        res.hit = 1'b0;
      endcase
      return res;
   endfunction

   function automatic bracket_type closer_decode(input logic [SYMBOL_W-1:0] sym);
      bracket_type res;
      res.hit = 1'b1;
      res.kind = KIND_ROUND;
      case (sym)
         CH_ROUND_CLOSE:  res.kind = KIND_ROUND;
         CH_SQUARE_CLOSE: res.kind = KIND_SQUARE;
         CH_CURLY_CLOSE:  res.kind = KIND_CURLY;
         CH_ANGLE_CLOSE:  res.kind = KIND_ANGLE;
         default:         res.hit = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// ----- src/bracket_nesting_checker_scorer_unit.sv -----
// Checks bracket nesting of a text line fed one byte per word on req_ (tlast marks the line's
// last byte) and returns one word per line on rsp_: status, base-5 completion score and the
// count of brackets left open. A closer met with a non-empty stack goes through a pop state
// (the stack RAM read is registered); openers and other bytes are taken in idle. At line end
// the block classifies the line, then for an incomplete line walks the open brackets for the
// score (RAM read, then shift-add-saturate in the single accumulator, stopping early once
// saturated), then hands the result to the output register; the input stays blocked from the
// last word of a line until then, including any wait for the previous result to be taken. The
// stack holds STACK_DEPTH brackets; its RAM is not cleared.
module bracket_nesting_checker_scorer_unit import bnc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SYMBOL_W-1:0]   req_tdata,   // [7:0] symbol
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [1:0] status, [64:2] score, [70:65] open_count
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_POP  = 6'b000010,
      S_EVAL = 6'b000100,
      S_WRD  = 6'b001000,
      S_WACC = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               corrupt_ff, corrupt_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   kind_type           ckind_ff, ckind_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               req_fire;
   logic               frozen;
   bracket_type        op;
   bracket_type        cl;
   logic [CNT_W-1:0]   depth_m1;
   logic [CNT_W-1:0]   idx_m1;
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [KIND_W-1:0]  rd_data;
   acc_ctl_type        acc_ctl;
   logic [SCORE_W-1:0] acc_score;
   logic               acc_sat;
   status_type         line_status;
   logic               out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign frozen = corrupt_ff || ovf_ff;
   assign op = opener_decode(req_tdata);
   assign cl = closer_decode(req_tdata);
   assign depth_m1 = depth_ff - CNT_W'(1);
   assign idx_m1 = idx_ff - CNT_W'(1);
   assign wr_en = req_fire && !frozen && op.hit && (32'(depth_ff) < STACK_DEPTH);
   assign rd_addr = (state_ff == S_WRD) ? idx_m1[ADDR_W-1:0] : depth_m1[ADDR_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (corrupt_ff) begin
         line_status = STATUS_CORRUPTED;
      end else if (ovf_ff) begin
         line_status = STATUS_OVERFLOW;
      end else if (depth_ff == '0) begin
         line_status = STATUS_BALANCED;
      end else begin
         line_status = STATUS_INCOMPLETE;
      end
   end

   bnc_ram #(
      .WIDTH(KIND_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(depth_ff[ADDR_W-1:0]),
      .wr_data(op.kind),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   bnc_score_acc u_acc (
      .clock    (clock),
      .ctl      (acc_ctl),
      .score    (acc_score),
      .saturated(acc_sat)
   );

   always_comb begin
      state_in = state_ff;
      depth_in = depth_ff;
      idx_in = idx_ff;
      corrupt_in = corrupt_ff;
      ovf_in = ovf_ff;
      last_in = last_ff;
      ckind_in = ckind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_score_in = rsp_score_ff;
      rsp_count_in = rsp_count_ff;
      acc_ctl.clear = 1'b0;
      acc_ctl.step = 1'b0;
      acc_ctl.digit_kind = kind_type'(rd_data);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               last_in = req_tlast;
               ckind_in = cl.kind;
               state_in = req_tlast ? S_EVAL : S_IDLE;
               if (!frozen && op.hit) begin
                  if (32'(depth_ff) >= STACK_DEPTH) begin
                     ovf_in = 1'b1;
                  end else begin
                     depth_in = depth_ff + CNT_W'(1);
                  end
               end else if (!frozen && cl.hit) begin
                  if (depth_ff == '0) begin
                     corrupt_in = 1'b1;
                  end else begin
                     state_in = S_POP;
                  end
               end
            end
         end
         S_POP: begin
            if (rd_data == ckind_ff) begin
               depth_in = depth_m1;
            end else begin
               corrupt_in = 1'b1;
            end
            state_in = last_ff ? S_EVAL : S_IDLE;
         end
         S_EVAL: begin
            if (line_status == STATUS_INCOMPLETE) begin
               idx_in = depth_ff;
               acc_ctl.clear = 1'b1;
               state_in = S_WRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WRD: begin
            idx_in = idx_m1;
            state_in = S_WACC;
         end
         S_WACC: begin
            acc_ctl.step = 1'b1;
            state_in = (idx_ff == '0 || acc_sat) ? S_DONE : S_WRD;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = line_status;
               rsp_score_in = (line_status == STATUS_INCOMPLETE) ? acc_score : '0;
               if (32'(depth_ff) > COUNT_MAX) begin
                  rsp_count_in = COUNT_W'(COUNT_MAX);
               end else begin
                  rsp_count_in = COUNT_W'(depth_ff);
               end
               depth_in = '0;
               corrupt_in = 1'b0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         depth_ff <= '0;
         corrupt_ff <= 1'b0;
         ovf_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         depth_ff <= depth_in;
         corrupt_ff <= corrupt_in;
         ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      last_ff <= last_in;
      ckind_ff <= ckind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_score_ff <= rsp_score_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {1'b0, rsp_count_ff, rsp_score_ff, rsp_status_ff};

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      32'(depth_ff) <= STACK_DEPTH)
      else $error("stack depth past capacity");

   a_score_only_incomplete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_INCOMPLETE |-> rsp_score_ff == '0)
      else $error("score set on a line that is not incomplete");

   a_incomplete_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_INCOMPLETE |-> rsp_count_ff != '0
                                                        && rsp_score_ff != '0)
      else $error("incomplete line without open brackets");

   a_balanced_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_BALANCED |-> rsp_count_ff == '0)
      else $error("balanced line with open brackets");

   a_busy_after_closer: assert property (@(posedge clock) disable iff (reset)
      req_fire && !frozen && cl.hit && depth_ff != '0 |=> !req_tready)
      else $error("closer pop overlapped with next word");

endmodule

// ----- src/bnc_ram.sv -----
module bnc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/bnc_score_acc.sv -----
module bnc_score_acc import bnc_pkg::*; (
   input  logic               clock,
   input  acc_ctl_type        ctl,
   output logic [SCORE_W-1:0] score,
   output logic               saturated
);

   logic [SCORE_W-1:0] acc_ff, acc_in;
   logic               sat_ff, sat_in;
   logic [SCORE_W+2:0] sum;

   // acc * 5 + digit, digit = kind + 1
   assign sum = {1'b0, acc_ff, 2'b00} + {3'b000, acc_ff}
                + {{(SCORE_W+1){1'b0}}, ctl.digit_kind} + (SCORE_W+3)'(1);

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (ctl.clear) begin
         acc_in = '0;
         sat_in = 1'b0;
      end else if (ctl.step && !sat_ff) begin
         if (sum > {3'b000, SCORE_MAX}) begin
            acc_in = SCORE_MAX;
            sat_in = 1'b1;
         end else begin
            acc_in = sum[SCORE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sat_ff <= sat_in;
   end

   assign score = acc_ff;
   assign saturated = sat_ff;

endmodule

// ----- verif/bracket_nesting_checker_scorer_unit_tb.sv -----
module bracket_nesting_checker_scorer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bnc_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEFAULT;
   localparam int TOTAL_WORDS = 1650;
   localparam int IDLE_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      status_type         status;
      logic [SCORE_W-1:0] score;
      logic [COUNT_W-1:0] open_count;
   } line_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SYMBOL_W-1:0]   req_tdata = '0;   // [7:0] symbol
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // [1:0] status, [64:2] score, [70:65] open_count

   // predicted line state
   kind_type    open_kinds[DEPTH];
   int unsigned open_depth = 0;
   bit          line_corrupt = 1'b0;
   bit          line_overflow = 1'b0;

   line_result_type     owed_lines[$];
   logic [SYMBOL_W-1:0] line_buf[$];

   int mismatches = 0;
   int burst_left = 0;
   int sent_words = 0;
   int idle_cycles = 0;
   int rx_mode = 0;
   int rx_left = 0;

   bracket_nesting_checker_scorer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [SYMBOL_W-1:0] open_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CH_ROUND_OPEN;
         KIND_SQUARE: return CH_SQUARE_OPEN;
         KIND_CURLY:  return CH_CURLY_OPEN;
         default:     return CH_ANGLE_OPEN;
      endcase
   endfunction

   function automatic logic [SYMBOL_W-1:0] close_char(input kind_type k);
      case (k)
         KIND_ROUND:  return CH_ROUND_CLOSE;
         KIND_SQUARE: return CH_SQUARE_CLOSE;
         KIND_CURLY:  return CH_CURLY_CLOSE;
         default:     return CH_ANGLE_CLOSE;
      endcase
   endfunction

   function automatic logic [SCORE_W-1:0] completion_value();
      longint unsigned acc;
      longint unsigned digit;
      longint unsigned cap;
      acc = 0;
      cap = {1'b0, SCORE_MAX};
      for (int i = int'(open_depth) - 1; i >= 0; i--) begin
         digit = longint'(open_kinds[i]) + 1;
         if (acc > (cap - digit) / 5) return SCORE_MAX;
         acc = acc * 5 + digit;
      end
      return acc[SCORE_W-1:0];
   endfunction

   // advance the predicted line by one word; returns 1 when the word closes the line
   function automatic bit track_symbol(input logic [SYMBOL_W-1:0] sym, input logic last,
                                       output line_result_type res);
      bit       is_open;
      bit       is_close;
      kind_type k;
      is_open = 1'b0;
      is_close = 1'b0;
      k = KIND_ROUND;
      case (sym)
         CH_ROUND_OPEN:   begin is_open = 1'b1; k = KIND_ROUND; end
         CH_SQUARE_OPEN:  begin is_open = 1'b1; k = KIND_SQUARE; end
         CH_CURLY_OPEN:   begin is_open = 1'b1; k = KIND_CURLY; end
         CH_ANGLE_OPEN:   begin is_open = 1'b1; k = KIND_ANGLE; end
         CH_ROUND_CLOSE:  begin is_close = 1'b1; k = KIND_ROUND; end
         CH_SQUARE_CLOSE: begin is_close = 1'b1; k = KIND_SQUARE; end
         CH_CURLY_CLOSE:  begin is_close = 1'b1; k = KIND_CURLY; end
         CH_ANGLE_CLOSE:  begin is_close = 1'b1; k = KIND_ANGLE; end
         default: ;
      endcase
      if (!line_corrupt && !line_overflow) begin
         if (is_open) begin
            if (open_depth >= DEPTH) begin
               line_overflow = 1'b1;
            end else begin
               open_kinds[open_depth] = k;
               open_depth++;
            end
         end else if (is_close) begin
            if (open_depth == 0 || open_kinds[open_depth-1] != k) line_corrupt = 1'b1;
            else open_depth--;
         end
      end
      res.status = STATUS_BALANCED;
      res.score = '0;
      res.open_count = (open_depth > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(open_depth);
      if (!last) return 1'b0;
      if (line_corrupt) begin
         res.status = STATUS_CORRUPTED;
      end else if (line_overflow) begin
         res.status = STATUS_OVERFLOW;
      end else if (open_depth != 0) begin
         res.status = STATUS_INCOMPLETE;
         res.score = completion_value();
      end
      open_depth = 0;
      line_corrupt = 1'b0;
      line_overflow = 1'b0;
      return 1'b1;
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t ns: %s", $realtime, msg);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_word(input logic [SYMBOL_W-1:0] sym, input logic last);
      int              gap;
      line_result_type res;
      if (burst_left == 0) begin
         if ($urandom_range(0, 7) == 0) begin
            gap = 0;
            burst_left = $urandom_range(40, 120);
         end else begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 24);
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= sym;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (track_symbol(sym, last, res)) owed_lines.push_back(res);
      burst_left--;
      sent_words++;
      @(negedge clock);
   endtask

   task automatic flush_line();
      for (int i = 0; i < line_buf.size(); i++) send_word(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
      flush_line();
   endtask

   task automatic send_run(input logic [SYMBOL_W-1:0] sym, input int n, input string tail);
      repeat (n) line_buf.push_back(sym);
      send_text(tail);
   endtask

   // hold off until every owed line result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (owed_lines.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_pairs();
      send_text("()");
      send_text("[]");
      send_text("{}");
      send_text("<>");
      send_text("(");
      send_text("[");
      send_text("{");
      send_text("<");
   endtask

   task automatic test_nested_score();
      send_text("<{[(");
      send_text("([{<>}])");
      send_text("(<>[{");
   endtask

   task automatic test_wrong_closer();
      send_text("(]");
      send_text("{>");
      send_text("(]((");
      send_text("[<)>]");
   endtask

   task automatic test_closer_on_empty();
      send_text(")");
      send_text("]");
      send_text("()}");
      send_text(">(");
   endtask

   task automatic test_non_bracket();
      line_buf.push_back(8'h00);
      flush_line();
      line_buf.push_back(8'hFF);
      flush_line();
      send_text("a(b)c");
      send_text("x{y");
   endtask

   task automatic test_depth_limits();
      send_run(CH_ANGLE_OPEN, DEPTH, "");
      send_run(CH_ANGLE_OPEN, DEPTH + 1, "");
      send_run(CH_ROUND_OPEN, DEPTH + 1, ")");
      send_run(CH_CURLY_OPEN, DEPTH + 1, "]");
      send_text("(]");
      line_buf.push_back(CH_ROUND_OPEN);
      line_buf.push_back(CH_SQUARE_CLOSE);
      send_run(CH_ROUND_OPEN, DEPTH + 2, "");
   endtask

   task automatic test_saturation();
      send_run(CH_ANGLE_OPEN, 27, "");
      send_run(CH_ANGLE_OPEN, 28, "");
      send_run(CH_ROUND_OPEN, 27, "");
      send_run(CH_ROUND_OPEN, 28, "");
      send_run(CH_SQUARE_OPEN, 30, "]");
   endtask

   task automatic test_pause_midline();
      send_text("{{{");
      drain_results();
      line_buf.push_back(CH_CURLY_OPEN);
      line_buf.push_back(CH_SQUARE_OPEN);
      send_word(CH_SQUARE_OPEN, 1'b0);
      drain_results();
      send_text("]]");
   endtask

   task automatic make_random_line(input int len, input bit close_all, input int noise_pct,
                                   input int fault_pct);
      kind_type guide[$];
      kind_type k;
      int       r;
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         if (r < noise_pct) begin
            line_buf.push_back(SYMBOL_W'($urandom_range(0, 255)));
         end else if (r < noise_pct + fault_pct) begin
            line_buf.push_back(close_char(kind_type'($urandom_range(0, 3))));
         end else if (guide.size() != 0 && $urandom_range(0, 1)) begin
            line_buf.push_back(close_char(guide.pop_back()));
         end else begin
            k = kind_type'($urandom_range(0, 3));
            guide.push_back(k);
            line_buf.push_back(open_char(k));
         end
      end
      if (close_all) begin
         while (guide.size() != 0) line_buf.push_back(close_char(guide.pop_back()));
      end
      if (line_buf.size() == 0) line_buf.push_back(SYMBOL_W'($urandom_range(0, 255)));
   endtask

   task automatic test_random_lines();
      int pick;
      while (sent_words < TOTAL_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            make_random_line($urandom_range(1, 12), $urandom_range(0, 1), 5, 0);
         end else if (pick < 80) begin
            make_random_line($urandom_range(2, 16), $urandom_range(0, 1), 5, 10);
         end else if (pick < 90) begin
            make_random_line($urandom_range(1, 6), 1'b0, 100, 0);
         end else if (pick < 97) begin
            make_random_line($urandom_range(12, 40), $urandom_range(0, 1), 0, 0);
         end else begin
            repeat ($urandom_range(26, DEPTH + 3))
               line_buf.push_back(open_char(kind_type'($urandom_range(0, 3))));
            make_random_line($urandom_range(0, 4), 1'b0, 10, 20);
         end
         flush_line();
         if ($urandom_range(0, 149) == 0) drain_results();
      end
   endtask

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_left <= $urandom_range(10, 80);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= $urandom_range(0, 1);
         2:       rsp_tready <= ($urandom_range(0, 5) == 0);
         default: rsp_tready <= (rx_left < 3);
      endcase
   end

   always @(posedge clock) begin : check_rsp
      line_result_type    want;
      status_type         got_status;
      logic [SCORE_W-1:0] got_score;
      logic [COUNT_W-1:0] got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = status_type'(rsp_tdata[1:0]);
         got_score = rsp_tdata[64:2];
         got_count = rsp_tdata[70:65];
         if (owed_lines.size() == 0) begin
            log_mismatch($sformatf("unexpected word: status %0d score %0d open_count %0d",
                                   got_status, got_score, got_count));
         end else begin
            want = owed_lines.pop_front();
            if (got_status != want.status)
               log_mismatch($sformatf("status: expected %0d, got %0d", want.status, got_status));
            if (got_score != want.score)
               log_mismatch($sformatf("score: expected %0d, got %0d", want.score, got_score));
            if (got_count != want.open_count)
               log_mismatch($sformatf("open_count: expected %0d, got %0d",
                                      want.open_count, got_count));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bracket_nesting_checker_scorer_unit_tb: errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_pairs();
      test_nested_score();
      test_wrong_closer();
      test_closer_on_empty();
      test_non_bracket();
      test_depth_limits();
      test_saturation();
      test_pause_midline();
      test_random_lines();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && owed_lines.size() == 0) begin
         $display("bracket_nesting_checker_scorer_unit_tb: clean");
      end else begin
         $display("bracket_nesting_checker_scorer_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/bnc_pkg.sv
src/bnc_ram.sv
src/bnc_score_acc.sv
src/bracket_nesting_checker_scorer_unit.sv
verif/bracket_nesting_checker_scorer_unit_tb.sv
